[rtl/zpnb_pkg.sv]
package zpnb_pkg;

  // default store geometry
  localparam int DEF_MAX_IMAGE_WIDTH  = 256;
  localparam int DEF_MAX_IMAGE_HEIGHT = 256;

  // field and register widths
  localparam int COL_W      = 11;
  localparam int PIX_W      = 24;
  localparam int IMG_W      = 9;
  localparam int VIEW_W     = 12;
  localparam int PAN_W      = 13;
  localparam int ZOOM_W     = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int TDATA_W    = 48;

  // internal datapath widths
  localparam int SCALED_W = 11;
  localparam int LIM_W    = 12;
  localparam int BASE_W   = 14;
  localparam int REL_W    = 15;
  localparam int N_W      = 18;
  localparam int SRC_W    = 9;
  localparam int SHIFT_W  = 2;
  localparam int NUM_W    = 2;

  // zoom selector codes
  localparam logic [ZOOM_W-1:0] ZOOM_QUARTER    = 3'd0;
  localparam logic [ZOOM_W-1:0] ZOOM_HALF       = 3'd1;
  localparam logic [ZOOM_W-1:0] ZOOM_UNIT       = 3'd2;
  localparam logic [ZOOM_W-1:0] ZOOM_THREE_HALF = 3'd3;
  localparam logic [ZOOM_W-1:0] ZOOM_DOUBLE     = 3'd4;

  // zoom numerators
  localparam logic [NUM_W-1:0] NUM_ONE   = 2'd1;
  localparam logic [NUM_W-1:0] NUM_TWO   = 2'd2;
  localparam logic [NUM_W-1:0] NUM_THREE = 2'd3;

  // shift for twice the zoom denominator
  localparam logic [SHIFT_W-1:0] SHIFT_DEN1 = 2'd1;
  localparam logic [SHIFT_W-1:0] SHIFT_DEN2 = 2'd2;
  localparam logic [SHIFT_W-1:0] SHIFT_DEN4 = 2'd3;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ZOOM_SELECT  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_X        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN_Y        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIEW_HEIGHT  = 3'd6;

  // word kinds on tuser
  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_RENDER = 1'b1;

  // register reset values
  localparam logic [IMG_W-1:0]  RST_IMAGE_WIDTH  = 9'd256;
  localparam logic [IMG_W-1:0]  RST_IMAGE_HEIGHT = 9'd256;
  localparam logic [VIEW_W-1:0] RST_VIEW_WIDTH   = 12'd616;
  localparam logic [VIEW_W-1:0] RST_VIEW_HEIGHT  = 12'd418;

  // divide by three: floor(x*683/2048) for x below 1536
  localparam logic [9:0] RECIP3       = 10'd683;
  localparam int         RECIP3_SHIFT = 11;

  typedef struct packed {
    logic [VIEW_W-1:0] view;
    logic [IMG_W-1:0]  size;
    logic [ZOOM_W-1:0] zoom;
    logic [PAN_W-1:0]  pan;
  } axis_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [SRC_W-1:0] src;
  } axis_res_t;

endpackage

[rtl/zpnb_ram.sv]
module zpnb_ram #(
  parameter int DATA_W = 24,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/zpnb_axis.sv]
module zpnb_axis (
  input  logic                             clk,
  input  logic                             en,
  input  zpnb_pkg::axis_cfg_t              cfg,
  input  logic [zpnb_pkg::COL_W-1:0]       pos,
  output zpnb_pkg::axis_res_t              res
);
  import zpnb_pkg::*;

  logic [SCALED_W-1:0]      scaled;
  logic [LIM_W-1:0]         lim;
  logic [NUM_W-1:0]         num;
  logic [SHIFT_W-1:0]       shift;
  logic [SCALED_W-1:0]      size_s;
  logic [LIM_W-1:0]         size_l;
  logic signed [BASE_W-1:0] diff;
  logic signed [BASE_W-1:0] half;
  logic signed [BASE_W-1:0] base;

  logic signed [BASE_W-1:0] base_r;
  logic [LIM_W-1:0]         lim_r;
  logic [NUM_W-1:0]         num_r;
  logic [SHIFT_W-1:0]       shift_r;
  logic                     size_nz_r;

  logic signed [REL_W-1:0]  rel;
  logic signed [N_W-1:0]    n_nxt;
  logic signed [N_W-1:0]    n_r;
  logic                     pos_ok_r;

  logic [2:0]               twonum;
  logic signed [N_W-1:0]    neg_bound;
  logic [LIM_W-1:0]         n_u;
  logic [20:0]              prod;
  logic                     in_rng;
  logic [SRC_W-1:0]         src;
  logic                     inside_r;
  logic [SRC_W-1:0]         src_r;

  // scaled size, source limit and rational factors per zoom
  always_comb begin
    size_s = {2'b00, cfg.size};
    size_l = {3'b000, cfg.size};
    unique case (cfg.zoom)
      ZOOM_QUARTER: begin
        scaled = size_s >> 2;
        lim    = size_l << 1;
        num    = NUM_ONE;
        shift  = SHIFT_DEN4;
      end
      ZOOM_HALF: begin
        scaled = size_s >> 1;
        lim    = size_l << 1;
        num    = NUM_ONE;
        shift  = SHIFT_DEN2;
      end
      ZOOM_UNIT: begin
        scaled = size_s;
        lim    = size_l << 1;
        num    = NUM_ONE;
        shift  = SHIFT_DEN1;
      end
      ZOOM_THREE_HALF: begin
        scaled = (size_s + (size_s << 1)) >> 1;
        lim    = (size_l << 2) + (size_l << 1);
        num    = NUM_THREE;
        shift  = SHIFT_DEN2;
      end
      default: begin
        scaled = size_s << 1;
        lim    = size_l << 2;
        num    = NUM_TWO;
        shift  = SHIFT_DEN1;
      end
    endcase
  end

  // centered origin of the image plus pan, halving rounds toward zero
  always_comb begin
    diff = $signed({2'b00, cfg.view}) - $signed({3'b000, scaled});
    half = $signed(diff + $signed({{(BASE_W-1){1'b0}}, diff[BASE_W-1]})) >>> 1;
    base = $signed({{(BASE_W-PAN_W){cfg.pan[PAN_W-1]}}, cfg.pan}) + half;
  end

  // settings derived from registers, refreshed every cycle
  always_ff @(posedge clk) begin
    base_r    <= base;
    lim_r     <= lim;
    num_r     <= num;
    shift_r   <= shift;
    size_nz_r <= (cfg.size != '0);
  end

  // first stage: numerator 2*rel*den + num
  always_comb begin
    rel   = $signed({{(REL_W-COL_W){1'b0}}, pos}) - $signed({base_r[BASE_W-1], base_r});
    n_nxt = ($signed({{(N_W-REL_W){rel[REL_W-1]}}, rel}) <<< shift_r)
          + $signed({{(N_W-NUM_W){1'b0}}, num_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r      <= n_nxt;
      pos_ok_r <= ({1'b0, pos} < cfg.view);
    end
  end

  // second stage: truncating divide by 2*num and range check
  always_comb begin
    twonum    = {num_r, 1'b0};
    neg_bound = -$signed({{(N_W-3){1'b0}}, twonum});
    n_u       = n_r[LIM_W-1:0];
    prod      = {10'b0, n_u[LIM_W-1:1]} * {11'b0, RECIP3};
    if (n_r[N_W-1]) begin
      // band just before the edge truncates to source index zero
      in_rng = (n_r > neg_bound) && size_nz_r;
    end else begin
      in_rng = (n_r[N_W-2:LIM_W] == '0) && (n_u < lim_r);
    end
    unique case (num_r)
      NUM_ONE: src = n_u[SRC_W:1];
      NUM_TWO: src = n_u[SRC_W+1:2];
      default: src = prod[RECIP3_SHIFT +: SRC_W];
    endcase
    if (n_r[N_W-1]) begin
      src = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      inside_r <= pos_ok_r && in_rng;
      src_r    <= src;
    end
  end

  assign res.hit = inside_r;
  assign res.src = src_r;

endmodule

[rtl/zoom_pan_nearest_neighbor_blitter.sv]
// channel | dir | tdata (lsb first)                 | tuser
// in_     | in  | column, row, pixel_value, pad      | action
// out_    | out | color, dest_col, dest_row, pad     | inside_res
// cfg_    | in  | write enable, index, data          | -
//
// one word per cycle in each direction while the output word is taken, in order through the pipe
// the address mapping takes two stages, the pixel store one read stage
// reset clears the valid bits and the registers to their reset values
// the whole pipe stalls while the output word waits; in_tready follows it
// load words pass through the pipe and write the store, yielding no output
module zoom_pan_nearest_neighbor_blitter
  import zpnb_pkg::*;
#(
  parameter int MAX_IMAGE_WIDTH  = DEF_MAX_IMAGE_WIDTH,
  parameter int MAX_IMAGE_HEIGHT = DEF_MAX_IMAGE_HEIGHT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [TDATA_W-1:0]    in_tdata,   // column[10:0], row[21:11], pixel_value[45:22]
  input  logic [0:0]            in_tuser,   // action
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [TDATA_W-1:0]    out_tdata,  // color[23:0], dest_col[34:24], dest_row[45:35]
  output logic [0:0]            out_tuser,  // inside_res
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT;
  localparam int ADDR_W = $clog2(DEPTH);

  // configuration registers
  logic [IMG_W-1:0]  img_w_r, img_h_r;
  logic [ZOOM_W-1:0] zoom_r;
  logic [PAN_W-1:0]  pan_x_r, pan_y_r;
  logic [VIEW_W-1:0] view_w_r, view_h_r;

  logic [IMG_W-1:0]  size_x, size_y;
  logic [ZOOM_W-1:0] zoom_sat;
  axis_cfg_t         cfg_x, cfg_y;
  axis_res_t         res_x, res_y;

  logic en;

  // pipeline stage registers
  logic              v1_r, v2_r, v3_r, v4_r;
  logic              act1_r, act2_r, act3_r;
  logic [COL_W-1:0]  col1_r, col2_r, col3_r, col4_r;
  logic [COL_W-1:0]  row1_r, row2_r, row3_r, row4_r;
  logic [PIX_W-1:0]  pix1_r, pix2_r, pix3_r;
  logic              ldok2_r, ldok3_r;
  logic [ADDR_W-1:0] ld_addr3_r;
  logic              inside4_r;

  logic [ADDR_W-1:0] rd_addr;
  logic              ram_we, ram_re;
  logic [PIX_W-1:0]  ram_rdata;

  // output register
  logic              out_valid_r;
  logic              out_inside_r;
  logic [PIX_W-1:0]  out_color_r;
  logic [COL_W-1:0]  out_col_r, out_row_r;

  assign en = !out_valid_r || out_tready;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_w_r  <= RST_IMAGE_WIDTH;
      img_h_r  <= RST_IMAGE_HEIGHT;
      zoom_r   <= ZOOM_UNIT;
      pan_x_r  <= '0;
      pan_y_r  <= '0;
      view_w_r <= RST_VIEW_WIDTH;
      view_h_r <= RST_VIEW_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IMAGE_WIDTH:  img_w_r  <= cfg_wdata[IMG_W-1:0];
        CFG_IMAGE_HEIGHT: img_h_r  <= cfg_wdata[IMG_W-1:0];
        CFG_ZOOM_SELECT:  zoom_r   <= cfg_wdata[ZOOM_W-1:0];
        CFG_PAN_X:        pan_x_r  <= cfg_wdata[PAN_W-1:0];
        CFG_PAN_Y:        pan_y_r  <= cfg_wdata[PAN_W-1:0];
        CFG_VIEW_WIDTH:   view_w_r <= cfg_wdata[VIEW_W-1:0];
        CFG_VIEW_HEIGHT:  view_h_r <= cfg_wdata[VIEW_W-1:0];
        default: ;
      endcase
    end
  end

  // saturate image size and zoom selector
  always_comb begin
    size_x   = (32'(img_w_r) > 32'(MAX_IMAGE_WIDTH)) ? IMG_W'(MAX_IMAGE_WIDTH) : img_w_r;
    size_y   = (32'(img_h_r) > 32'(MAX_IMAGE_HEIGHT)) ? IMG_W'(MAX_IMAGE_HEIGHT) : img_h_r;
    zoom_sat = (zoom_r > ZOOM_DOUBLE) ? ZOOM_DOUBLE : zoom_r;
    cfg_x    = '{view: view_w_r, size: size_x, zoom: zoom_sat, pan: pan_x_r};
    cfg_y    = '{view: view_h_r, size: size_y, zoom: zoom_sat, pan: pan_y_r};
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r && (act3_r == ACT_RENDER);
    end
  end

  // payload through the mapping stages
  always_ff @(posedge clk) begin
    if (en) begin
      act1_r     <= in_tuser[0];
      col1_r     <= in_tdata[10:0];
      row1_r     <= in_tdata[21:11];
      pix1_r     <= in_tdata[45:22];
      act2_r     <= act1_r;
      col2_r     <= col1_r;
      row2_r     <= row1_r;
      pix2_r     <= pix1_r;
      ldok2_r    <= (32'(col1_r) < 32'(MAX_IMAGE_WIDTH))
                 && (32'(row1_r) < 32'(MAX_IMAGE_HEIGHT));
      act3_r     <= act2_r;
      col3_r     <= col2_r;
      row3_r     <= row2_r;
      pix3_r     <= pix2_r;
      ldok3_r    <= ldok2_r;
      ld_addr3_r <= ADDR_W'(32'(row2_r) * 32'(MAX_IMAGE_WIDTH) + 32'(col2_r));
      col4_r     <= col3_r;
      row4_r     <= row3_r;
      inside4_r  <= res_x.hit && res_y.hit;
    end
  end

  zpnb_axis u_axis_x (
    .clk (clk),
    .en  (en),
    .cfg (cfg_x),
    .pos (col1_r),
    .res (res_x)
  );

  zpnb_axis u_axis_y (
    .clk (clk),
    .en  (en),
    .cfg (cfg_y),
    .pos (row1_r),
    .res (res_y)
  );

  // store access: one word per enabled cycle in order, so a read always sees earlier writes
  always_comb begin
    rd_addr = ADDR_W'(32'(res_y.src) * 32'(MAX_IMAGE_WIDTH) + 32'(res_x.src));
    ram_we  = en && v3_r && (act3_r == ACT_LOAD) && ldok3_r;
    ram_re  = en && v3_r && (act3_r == ACT_RENDER);
  end

  zpnb_ram #(
    .DATA_W (PIX_W),
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ld_addr3_r),
    .wdata (pix3_r),
    .re    (ram_re),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_inside_r <= inside4_r;
      out_color_r  <= inside4_r ? ram_rdata : '0;
      out_col_r    <= col4_r;
      out_row_r    <= row4_r;
    end
  end

  // no word is taken while reset is held
  assign in_tready  = en && rst_n;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_inside_r;
  assign out_tdata  = {2'b00, out_row_r, out_col_r, out_color_r};

endmodule

[rtl/zpnb_checker.sv]
module zpnb_checker
  import zpnb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [TDATA_W-1:0]    out_tdata,
  input logic [0:0]            out_tuser
);

  // no output word right after reset
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output word valid after reset");

  // input only backs up when the output word is stalled
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (out_tvalid && !out_tready))
    else $error("input stalled without output backpressure");

  // a word off the image carries black
  a_outside_black: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[PIX_W-1:0] == '0))
    else $error("outside word with nonzero color");

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=>
      (out_tvalid && $stable(out_tdata) && $stable(out_tuser)))
    else $error("stalled output word changed");

endmodule

bind zoom_pan_nearest_neighbor_blitter zpnb_checker u_zpnb_checker (.*);

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import zpnb_pkg::*;

  localparam int MAX_W       = DEF_MAX_IMAGE_WIDTH;
  localparam int MAX_H       = DEF_MAX_IMAGE_HEIGHT;
  localparam int COORD_MAX   = (1 << COL_W) - 1;
  localparam int PAD_W       = TDATA_W - PIX_W - 2 * COL_W;
  localparam int NUM_REGS    = 7;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 2000;
  localparam int PRINT_LIMIT = 40;

  // selector codes with no zoom of their own, they behave as 200%
  localparam logic [ZOOM_W-1:0] ZOOM_UNUSED_LO = 3'd5;
  localparam logic [ZOOM_W-1:0] ZOOM_UNUSED_HI = 3'd7;

  typedef enum {READY_ALWAYS, READY_COIN, READY_EVERY_FOURTH, READY_MOSTLY} ready_mode_t;

  typedef struct {
    logic [IMG_W-1:0]  img_w;
    logic [IMG_W-1:0]  img_h;
    logic [ZOOM_W-1:0] zoom;
    logic [PAN_W-1:0]  pan_x;
    logic [PAN_W-1:0]  pan_y;
    logic [VIEW_W-1:0] view_w;
    logic [VIEW_W-1:0] view_h;
  } blit_setting_t;

  typedef struct {
    logic              hit;
    logic [PIX_W-1:0]  color;
    logic [COL_W-1:0]  col;
    logic [COL_W-1:0]  row;
  } view_pixel_t;

  logic                  clk;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [TDATA_W-1:0]    in_tdata = '0;
  logic [0:0]            in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [TDATA_W-1:0]    out_tdata;
  logic [0:0]            out_tuser;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // shadow of the block: registers and pixel store
  blit_setting_t    cur;
  logic [PIX_W-1:0] pixel_mem [0:MAX_W*MAX_H-1];
  bit               loaded    [0:MAX_W*MAX_H-1];
  view_pixel_t      expected_pixels [$];

  int  errors = 0;
  int  n_renders = 0;
  int  n_inside = 0;
  int  n_loads = 0;
  int  n_settings = 0;
  int  burst_left = 0;
  int  stall_cycles = 0;
  bit  steady = 1'b0;
  bit  hold_request = 1'b0;

  zoom_pan_nearest_neighbor_blitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // one axis of the view-to-source mapping, -1 when off the view or the image
  function automatic int source_index(int pos, int view, int size, int pan, int num, int den);
    int scaled;
    int base;
    int rel;
    int src;
    scaled = (size * num) / den;
    base = pan + (view - scaled) / 2;
    rel = pos - base;
    src = (2 * rel * den + num) / (2 * num);
    if (pos >= view || src < 0 || src >= size) return -1;
    return src;
  endfunction

  // maps a view pixel onto the source image under the current setting
  function automatic bit map_view_pixel(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row,
                                        output int sx, output int sy);
    int num;
    int den;
    int iw;
    int ih;
    case (cur.zoom)
      ZOOM_QUARTER:    begin num = 1; den = 4; end
      ZOOM_HALF:       begin num = 1; den = 2; end
      ZOOM_UNIT:       begin num = 1; den = 1; end
      ZOOM_THREE_HALF: begin num = 3; den = 2; end
      default:         begin num = 2; den = 1; end
    endcase
    iw = (int'(cur.img_w) > MAX_W) ? MAX_W : int'(cur.img_w);
    ih = (int'(cur.img_h) > MAX_H) ? MAX_H : int'(cur.img_h);
    sx = source_index(int'(col), int'(cur.view_w), iw, int'($signed(cur.pan_x)), num, den);
    sy = source_index(int'(row), int'(cur.view_h), ih, int'($signed(cur.pan_y)), num, den);
    return (sx >= 0 && sy >= 0);
  endfunction

  // update the shadow store or queue the expected pixel for an accepted word
  task automatic track_word(input logic act, input logic [COL_W-1:0] col,
                            input logic [COL_W-1:0] row, input logic [PIX_W-1:0] pix);
    view_pixel_t want;
    int sx;
    int sy;
    if (act == ACT_LOAD) begin
      n_loads++;
      if (col < MAX_W && row < MAX_H) begin
        pixel_mem[row * MAX_W + col] = pix;
        loaded[row * MAX_W + col] = 1'b1;
      end
    end else begin
      want.hit = map_view_pixel(col, row, sx, sy);
      want.color = want.hit ? pixel_mem[sy * MAX_W + sx] : '0;
      want.col = col;
      want.row = row;
      expected_pixels.push_back(want);
      n_renders++;
      if (want.hit) n_inside++;
    end
  endtask

  // offer one word, with bursts and gaps, and wait for the handshake
  task automatic send_word(input logic act, input logic [COL_W-1:0] col,
                           input logic [COL_W-1:0] row, input logic [PIX_W-1:0] pix);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= {{PAD_W{1'b0}}, pix, row, col};
    do @(posedge clk); while (!in_tready);
    track_word(act, col, row, pix);
  endtask

  // render a view pixel, loading its source pixel first if never written
  task automatic send_render(input logic [COL_W-1:0] col, input logic [COL_W-1:0] row);
    int sx;
    int sy;
    if (map_view_pixel(col, row, sx, sy) && !loaded[sy * MAX_W + sx])
      send_word(ACT_LOAD, COL_W'(sx), COL_W'(sy), PIX_W'($urandom));
    send_word(ACT_RENDER, col, row, PIX_W'($urandom));
  endtask

  // stop offering, let every pending pixel arrive and the pipe drain
  task automatic wait_quiet();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all seven registers on consecutive cycles while idle
  task automatic apply_setting(input blit_setting_t s);
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] v;
    wait_quiet();
    for (int i = 0; i < NUM_REGS; i++) begin
      idx = CFG_IDX_W'(i);
      case (idx)
        CFG_IMAGE_WIDTH:  v = CFG_DATA_W'(s.img_w);
        CFG_IMAGE_HEIGHT: v = CFG_DATA_W'(s.img_h);
        CFG_ZOOM_SELECT:  v = CFG_DATA_W'(s.zoom);
        CFG_PAN_X:        v = CFG_DATA_W'(s.pan_x);
        CFG_PAN_Y:        v = CFG_DATA_W'(s.pan_y);
        CFG_VIEW_WIDTH:   v = CFG_DATA_W'(s.view_w);
        default:          v = CFG_DATA_W'(s.view_h);
      endcase
      cfg_we    <= 1'b1;
      cfg_index <= idx;
      cfg_wdata <= v;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    cur = s;
    n_settings++;
  endtask

  function automatic blit_setting_t make_setting(int w, int h, logic [ZOOM_W-1:0] zoom,
                                                 int px, int py, int vw, int vh);
    blit_setting_t s;
    s.img_w  = IMG_W'(w);
    s.img_h  = IMG_W'(h);
    s.zoom   = zoom;
    s.pan_x  = PAN_W'(px);
    s.pan_y  = PAN_W'(py);
    s.view_w = VIEW_W'(vw);
    s.view_h = VIEW_W'(vh);
    return s;
  endfunction

  function automatic int random_size();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom_range(1, 24);
    if (pick == 6) return 0;
    if (pick == 7) return $urandom_range(MAX_W + 1, (1 << IMG_W) - 1);
    return $urandom_range(25, MAX_W);
  endfunction

  function automatic int random_view();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 12) return $urandom_range(4, 80);
    if (pick < 15) return $urandom_range(0, 3);
    return $urandom_range(81, (1 << VIEW_W) - 1);
  endfunction

  function automatic int random_pan();
    if ($urandom_range(0, 9) < 7) return $urandom_range(0, 20) - 10;
    return int'($signed(PAN_W'($urandom)));
  endfunction

  // coordinate mostly within the view, a little past it, sometimes anywhere
  function automatic logic [COL_W-1:0] pick_coord(int view);
    if (view == 0 || $urandom_range(0, 9) == 0) return COL_W'($urandom_range(0, COORD_MAX));
    return COL_W'($urandom_range(0, (view < COORD_MAX) ? view + 1 : COORD_MAX));
  endfunction

  // random mix of renders and loads under the current setting
  task automatic random_traffic(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 75)
        send_render(pick_coord(int'(cur.view_w)), pick_coord(int'(cur.view_h)));
      else if (pick < 80)
        send_render(COL_W'($urandom_range(0, COORD_MAX)), COL_W'($urandom_range(0, COORD_MAX)));
      else if (pick < 92)
        send_word(ACT_LOAD, COL_W'($urandom_range(0, MAX_W - 1)),
                  COL_W'($urandom_range(0, MAX_H - 1)), PIX_W'($urandom));
      else
        send_word(ACT_LOAD, COL_W'($urandom_range(0, COORD_MAX)),
                  COL_W'($urandom_range(0, COORD_MAX)), PIX_W'($urandom));
    end
  endtask

  task automatic phase_run(input blit_setting_t s, input int count);
    apply_setting(s);
    random_traffic(count);
  endtask

  // reset setting: image 256x256 at 100%, centred with its top left at 180,81 in a 616x418 view
  task automatic test_reset_view();
    send_word(ACT_LOAD, COL_W'(COORD_MAX), COL_W'(COORD_MAX), '1);  // outside the store, ignored
    send_word(ACT_LOAD, COL_W'(MAX_W), COL_W'(0), 24'h123456);      // column just past the store
    send_word(ACT_LOAD, COL_W'(0), COL_W'(MAX_H), 24'h654321);      // row just past the store
    send_word(ACT_LOAD, COL_W'(0), COL_W'(0), '1);
    send_word(ACT_LOAD, COL_W'(MAX_W - 1), COL_W'(MAX_H - 1), '0);
    send_word(ACT_LOAD, COL_W'(MAX_W - 1), COL_W'(0), 24'ha5a5a5);
    send_word(ACT_LOAD, COL_W'(0), COL_W'(MAX_H - 1), 24'h5a5a5a);
    send_render(COL_W'(180), COL_W'(81));                 // top left corner
    send_render(COL_W'(179), COL_W'(80));                 // band before the edge repeats it
    send_render(COL_W'(178), COL_W'(81));                 // just off the left edge
    send_render(COL_W'(435), COL_W'(336));                // bottom right corner
    send_render(COL_W'(436), COL_W'(336));                // just off the right edge
    send_render(COL_W'(435), COL_W'(81));
    send_render(COL_W'(180), COL_W'(336));
    send_render(COL_W'(0), COL_W'(0));
    send_render(COL_W'(COORD_MAX), COL_W'(COORD_MAX));    // outside the view
    send_render(COL_W'(615), COL_W'(417));                // last pixel of the view
    send_render(COL_W'(616), COL_W'(0));                  // first column past the view
    send_render(COL_W'(300), COL_W'(200));
  endtask

  // empty and oversized images, unused zoom codes, extreme pans and views
  task automatic test_edge_settings();
    phase_run(make_setting(0, 0, ZOOM_UNIT, 0, 0, 64, 64), 12);
    phase_run(make_setting(0, 12, ZOOM_HALF, 0, 0, 40, 40), 8);
    phase_run(make_setting((1 << IMG_W) - 1, 300, ZOOM_QUARTER, 0, 0, 4095, 4095), 20);
    phase_run(make_setting(1, 1, ZOOM_DOUBLE, 0, 0, 8, 8), 16);
    phase_run(make_setting(10, 8, ZOOM_UNUSED_LO, 0, 0, 40, 40), 16);
    phase_run(make_setting(10, 8, ZOOM_UNUSED_HI, 3, -2, 40, 40), 16);
    phase_run(make_setting(20, 20, ZOOM_HALF, -4096, 4095, 2048, 2048), 12);
    phase_run(make_setting(20, 20, ZOOM_THREE_HALF, 4095, -4096, 4095, 4095), 12);
    phase_run(make_setting(16, 16, ZOOM_UNIT, 0, 0, 0, 0), 12);
    phase_run(make_setting(MAX_W, MAX_H, ZOOM_DOUBLE, -100, 60, 2048, 1), 16);
    phase_run(make_setting(MAX_W, MAX_H, ZOOM_THREE_HALF, 0, 0, 1, 2048), 16);
  endtask

  // every zoom code on small images
  task automatic test_zoom_sweep();
    for (int z = ZOOM_QUARTER; z <= ZOOM_UNUSED_HI; z++)
      phase_run(make_setting($urandom_range(1, 16), $urandom_range(1, 16), ZOOM_W'(z),
                             $urandom_range(0, 12) - 6, $urandom_range(0, 12) - 6,
                             $urandom_range(8, 64), $urandom_range(8, 64)), 40);
  endtask

  task automatic test_random_settings();
    repeat (12)
      phase_run(make_setting(random_size(), random_size(), ZOOM_W'($urandom_range(0, 7)),
                             random_pan(), random_pan(), random_view(), random_view()), 40);
  endtask

  // long receiver hold-off with the sender offering back to back
  task automatic test_backpressure();
    apply_setting(make_setting(16, 16, ZOOM_UNIT, 0, 0, 32, 32));
    steady = 1'b1;
    hold_request = 1'b1;
    random_traffic(80);
    steady = 1'b0;
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    errors++;
    if (errors <= PRINT_LIMIT)
      $display("mismatch at %0t: %s got %0h want %0h", $realtime, what, got, want);
  endtask

  // compare one output word with the oldest pending pixel
  task automatic check_word();
    view_pixel_t      want;
    logic [PIX_W-1:0] color;
    logic [COL_W-1:0] dcol;
    logic [COL_W-1:0] drow;
    color = out_tdata[PIX_W-1:0];
    dcol  = out_tdata[PIX_W +: COL_W];
    drow  = out_tdata[PIX_W+COL_W +: COL_W];
    if (expected_pixels.size() == 0) begin
      report_mismatch("word with nothing pending", 64'(out_tdata), '0);
      return;
    end
    want = expected_pixels.pop_front();
    if (out_tuser[0] !== want.hit)
      report_mismatch("inside flag", 64'(out_tuser), 64'(want.hit));
    if (color !== want.color) report_mismatch("color", 64'(color), 64'(want.color));
    if (dcol !== want.col) report_mismatch("dest column", 64'(dcol), 64'(want.col));
    if (drow !== want.row) report_mismatch("dest row", 64'(drow), 64'(want.row));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_word();
  end

  // receiver: changing ready patterns plus an occasional long hold-off
  initial begin : receiver
    ready_mode_t mode = READY_ALWAYS;
    int left = 0;
    int hold_left = 0;
    int tick = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        if (left == 0) begin
          mode = ready_mode_t'($urandom_range(0, 3));
          left = $urandom_range(16, 96);
        end
        left--;
        tick++;
        case (mode)
          READY_ALWAYS:       out_tready <= 1'b1;
          READY_COIN:         out_tready <= ($urandom_range(0, 1) == 1);
          READY_EVERY_FOURTH: out_tready <= (tick % 4 == 0);
          default:            out_tready <= ($urandom_range(0, 7) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d pixels pending",
               stall_cycles, expected_pixels.size());
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    cur = make_setting(RST_IMAGE_WIDTH, RST_IMAGE_HEIGHT, ZOOM_UNIT, 0, 0,
                       RST_VIEW_WIDTH, RST_VIEW_HEIGHT);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_view();
    test_edge_settings();
    test_zoom_sweep();
    test_random_settings();
    test_backpressure();
    wait_quiet();
    $display("summary: %0d renders (%0d on the image), %0d loads, %0d register settings",
             n_renders, n_inside, n_loads, n_settings);
    $display("summary: %0d mismatches", errors);
    if (errors == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
